/* hdl/guitar_effect_chain_core_defines.svh */
`ifndef GUITAR_EFFECT_CHAIN_CORE_DEFINES_SVH
`define GUITAR_EFFECT_CHAIN_CORE_DEFINES_SVH

// same-cycle implication
`define GEC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gec assertion failed");

// next-cycle implication
`define GEC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gec assertion failed");

`endif

/* hdl/gec_pkg.sv */
package gec_pkg;

   localparam int CW = 40;
   localparam logic [4:0] CORDIC_STEPS = 5'd30;
   localparam logic signed [CW-1:0] ONE_Q30 = 40'sd1073741824;
   localparam logic signed [CW-1:0] CORDIC_K = 40'sd652032875;
   localparam logic [18:0] DIV25_MUL = 19'd335544;

   localparam logic [2:0] CFG_ENABLES = 3'd0;
   localparam logic [2:0] CFG_SLOTS   = 3'd1;
   localparam logic [2:0] CFG_PREAMP  = 3'd2;
   localparam logic [2:0] CFG_DRIVE   = 3'd3;
   localparam logic [2:0] CFG_CLIP    = 3'd4;
   localparam logic [2:0] CFG_STEP    = 3'd5;
   localparam logic [2:0] CFG_DEPTH   = 3'd6;
   localparam logic [2:0] CFG_HOLD    = 3'd7;

   localparam logic [1:0] EFF_OD   = 2'd0;
   localparam logic [1:0] EFF_TREM = 2'd1;
   localparam logic [1:0] EFF_CLIP = 2'd2;
   localparam logic [1:0] EFF_HOLD = 2'd3;

   typedef enum logic [4:0] {
      ST_FILL_START, ST_FILL_RUN, ST_FILL_STORE, ST_IDLE, ST_START,
      ST_PRE_MUL, ST_PRE_FIN, ST_SELECT,
      ST_OD_MUL, ST_OD_RD, ST_OD_INT, ST_OD_FIN,
      ST_TR_MUL, ST_TR_Q1, ST_TR_Q2, ST_TR_Q3, ST_TR_G, ST_TR_XM, ST_TR_FIN,
      ST_CLIP, ST_HOLD, ST_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_FILL_START, OP_FILL_STORE, OP_LOAD,
      OP_PRE_MUL, OP_PRE_FIN,
      OP_OD_MUL, OP_OD_RD, OP_OD_INT, OP_OD_FIN,
      OP_TR_MUL, OP_TR_Q1, OP_TR_Q2, OP_TR_Q3, OP_TR_G, OP_TR_XM, OP_TR_FIN,
      OP_CLIP, OP_HOLD, OP_OUT
   } op_type;

   typedef struct packed {
      logic        bypass;
      logic        preamp_en;
      logic [3:0]  eff_en;
      logic [11:0] slots;
      logic        cordic_busy;
      logic        fill_end;
   } status_type;

   function automatic logic signed [CW-1:0] cordic_angle(input logic [4:0] i);
      logic signed [CW-1:0] a;
      case (i)
         5'd0:  a = 40'sd536870912;
         5'd1:  a = 40'sd316933406;
         5'd2:  a = 40'sd167458907;
         5'd3:  a = 40'sd85004756;
         5'd4:  a = 40'sd42667331;
         5'd5:  a = 40'sd21354465;
         5'd6:  a = 40'sd10679838;
         5'd7:  a = 40'sd5340245;
         5'd8:  a = 40'sd2670163;
         5'd9:  a = 40'sd1335087;
         5'd10: a = 40'sd667544;
         5'd11: a = 40'sd333772;
         5'd12: a = 40'sd166886;
         5'd13: a = 40'sd83443;
         5'd14: a = 40'sd41722;
         5'd15: a = 40'sd20861;
         5'd16: a = 40'sd10430;
         5'd17: a = 40'sd5215;
         5'd18: a = 40'sd2608;
         5'd19: a = 40'sd1304;
         5'd20: a = 40'sd652;
         5'd21: a = 40'sd326;
         5'd22: a = 40'sd163;
         5'd23: a = 40'sd81;
         5'd24: a = 40'sd41;
         5'd25: a = 40'sd20;
         5'd26: a = 40'sd10;
         5'd27: a = 40'sd5;
         5'd28: a = 40'sd3;
         5'd29: a = 40'sd1;
         default: a = 40'sd0;
      endcase
      return a;
   endfunction

endpackage

/* hdl/gec_cordic.sv */
module gec_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                sine_mode,
   input  logic signed [gec_pkg::CW-1:0]       x0,
   input  logic signed [gec_pkg::CW-1:0]       y0,
   input  logic signed [gec_pkg::CW-1:0]       z0,
   output logic                                busy,
   output logic signed [gec_pkg::CW-1:0]       x_out,
   output logic signed [gec_pkg::CW-1:0]       y_out,
   output logic signed [gec_pkg::CW-1:0]       z_out
);

   logic signed [gec_pkg::CW-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic signed [gec_pkg::CW-1:0] sx, sy, ang;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, mode_ff, mode_in, pos;

   always_comb begin
      sx = y_ff >>> cnt_ff;
      sy = x_ff >>> cnt_ff;
      ang = gec_pkg::cordic_angle(cnt_ff);
      pos = mode_ff ? !z_ff[gec_pkg::CW-1] : y_ff[gec_pkg::CW-1];
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      mode_in = mode_ff;
      if (start) begin
         x_in = x0;
         y_in = y0;
         z_in = z0;
         cnt_in = 5'd0;
         busy_in = 1'b1;
         mode_in = sine_mode;
      end else if (busy_ff) begin
         if (pos) begin
            x_in = x_ff - sx;
            y_in = y_ff + sy;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + sx;
            y_in = y_ff - sy;
            z_in = z_ff + ang;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == gec_pkg::CORDIC_STEPS - 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      mode_ff <= mode_in;
   end

   assign busy = busy_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

/* hdl/gec_datapath.sv */
module gec_datapath #(
   parameter int SAMPLE_BITS = 24,
   parameter int FUNC_TABLE_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gec_pkg::op_type               op,
   output gec_pkg::status_type           status,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [31:0]                   csr_wdata
);

   localparam int SB = SAMPLE_BITS;
   localparam int FB = SB - 1;
   localparam int L = $clog2(FUNC_TABLE_DEPTH);
   localparam int AW = L + 1;
   localparam int PW = SB + 16;
   localparam int P2W = SB + 17;
   localparam int TPW = SB + 33;
   localparam int TW = SB + 35;
   localparam int WW = SB + 40;
   localparam int SH1 = FB + 16 - L;
   localparam int SH0 = FB - L;
   localparam int CW = gec_pkg::CW;
   localparam logic signed [WW-1:0] S_MAX = (WW'(1) <<< FB) - WW'(1);
   localparam logic signed [WW-1:0] S_MIN = -S_MAX - WW'(1);

   function automatic logic signed [SB-1:0] sat_f(input logic signed [WW-1:0] v);
      logic signed [WW-1:0] c;
      if (v > S_MAX) c = S_MAX;
      else if (v < S_MIN) c = S_MIN;
      else c = v;
      return SB'(c);
   endfunction

   logic signed [31:0] sin_mem [FUNC_TABLE_DEPTH];
   logic signed [31:0] atan_mem [FUNC_TABLE_DEPTH + 1];

   logic [5:0]  enables_ff, enables_in;
   logic [11:0] slots_ff, slots_in;
   logic [15:0] preamp_gain_ff, preamp_gain_in, drive_ff, drive_in;
   logic [22:0] clip_level_ff, clip_level_in;
   logic [31:0] trem_step_ff, trem_step_in, trem_phase_ff, trem_phase_in;
   logic [7:0]  trem_depth_ff, trem_depth_in, hold_length_ff, hold_length_in;
   logic [7:0]  hold_count_ff, hold_count_in;
   logic signed [SB-1:0] held_ff, held_in, x_ff, x_in, rsp_ff, rsp_in;
   logic neg_ff, neg_in;
   logic [PW-1:0] od_prod_ff, od_prod_in;
   logic [15:0] frac_ff, frac_in;
   logic signed [49:0] od_dp_ff, od_dp_in;
   logic signed [31:0] od_base_ff, od_base_in;
   logic signed [31:0] atan_a_ff, atan_b_ff, sin_rd_ff;
   logic signed [P2W-1:0] pre_prod_ff, pre_prod_in;
   logic [38:0] tp_ff, tp_in;
   logic [13:0] qh_ff, qh_in;
   logic [22:0] n2_ff, n2_in;
   logic [17:0] q2_ff, q2_in;
   logic signed [32:0] g_ff, g_in;
   logic signed [TPW-1:0] tr_prod_ff, tr_prod_in;
   logic [AW-1:0] fill_idx_ff, fill_idx_in;
   logic fill_sine_ff, fill_sine_in, fill_neg_ff, fill_neg_in;

   logic [SB-1:0] ax;
   logic [PW-1:0] od_idx_full;
   logic od_sat;
   logic [AW-1:0] od_a0, od_a1;
   logic [15:0] od_frac;
   logic signed [32:0] od_diff, u33, base, tr_base;
   logic signed [33:0] od_v;
   logic signed [TW-1:0] od_t, od_r;
   logic [7:0] dcl;
   logic [17:0] h;
   logic [18:0] rh;
   logic [22:0] r2;
   logic [17:0] q2c;
   logic [31:0] qsum;
   logic nz;
   logic signed [WW-1:0] xw, cw;
   logic [7:0] hc1;
   logic [31:0] za;
   logic signed [CW-1:0] zs, cx0, cy0, cz0, cor_x, cor_y, cor_z, yc, zc;
   logic signed [31:0] sin_wr, atan_wr;
   logic cor_busy;

   gec_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .start     (op == gec_pkg::OP_FILL_START),
      .sine_mode (fill_sine_ff),
      .x0        (cx0),
      .y0        (cy0),
      .z0        (cz0),
      .busy      (cor_busy),
      .x_out     (cor_x),
      .y_out     (cor_y),
      .z_out     (cor_z)
   );

   // table fill
   always_comb begin
      za = 32'(fill_idx_ff[L-1:0]) << (32 - L);
      zs = CW'($signed(za));
      fill_neg_in = fill_neg_ff;
      if (fill_sine_ff) begin
         fill_neg_in = 1'b0;
         if (zs > gec_pkg::ONE_Q30) begin
            zs = zs - (gec_pkg::ONE_Q30 <<< 1);
            fill_neg_in = 1'b1;
         end else if (zs < -gec_pkg::ONE_Q30) begin
            zs = zs + (gec_pkg::ONE_Q30 <<< 1);
            fill_neg_in = 1'b1;
         end
         cx0 = gec_pkg::CORDIC_K;
         cy0 = '0;
         cz0 = zs;
      end else begin
         cx0 = gec_pkg::ONE_Q30;
         cy0 = $signed(CW'(fill_idx_ff) << (34 - L));
         cz0 = '0;
      end
      if (op != gec_pkg::OP_FILL_START) fill_neg_in = fill_neg_ff;
      yc = cor_y;
      if (cor_y > gec_pkg::ONE_Q30) yc = gec_pkg::ONE_Q30;
      if (cor_y < -gec_pkg::ONE_Q30) yc = -gec_pkg::ONE_Q30;
      sin_wr = fill_neg_ff ? 32'(-yc) : 32'(yc);
      zc = cor_z;
      if (cor_z < 0) zc = '0;
      if (cor_z > gec_pkg::ONE_Q30) zc = gec_pkg::ONE_Q30;
      atan_wr = 32'(zc);
   end

   // effect arithmetic
   always_comb begin
      ax = x_ff[SB-1] ? SB'(-x_ff) : x_ff;
      od_idx_full = od_prod_ff >> SH1;
      od_sat = od_idx_full >= PW'(FUNC_TABLE_DEPTH);
      od_a0 = od_sat ? AW'(FUNC_TABLE_DEPTH) : AW'(od_idx_full[L-1:0]);
      od_a1 = od_sat ? AW'(FUNC_TABLE_DEPTH) : od_a0 + AW'(1);
      od_frac = od_sat ? 16'd0 : 16'(od_prod_ff >> SH0);
      od_diff = 33'(atan_b_ff) - 33'(atan_a_ff);
      od_v = 34'(od_base_ff) + 34'(od_dp_ff >>> 16);
      od_t = (TW'(od_v) <<< FB) + TW'(1 <<< 29);
      od_r = od_t >>> 30;
      dcl = (trem_depth_ff > 8'd200) ? 8'd200 : trem_depth_ff;
      u33 = 33'sh40000000 - 33'(sin_rd_ff);
      h = tp_ff[38:21];
      rh = 19'(h) - 19'(qh_ff) * 19'd25;
      r2 = n2_ff - 23'(q2_ff) * 23'd25;
      q2c = (r2 >= 23'd25) ? q2_ff + 18'd1 : q2_ff;
      nz = ((r2 >= 23'd25) ? (r2 != 23'd25) : (r2 != 23'd0)) || (tp_ff[2:0] != 3'd0);
      qsum = (32'(qh_ff) << 18) + 32'(q2c);
      base = 33'sh40000000 - $signed({1'b0, qsum});
      tr_base = (nz && base > 33'sd0) ? base - 33'sd1 : base;
      xw = WW'(x_ff);
      cw = $signed(WW'({1'b0, clip_level_ff}));
      hc1 = (hold_count_ff == 8'd0) ? hold_length_ff : hold_count_ff;
   end

   always_comb begin
      enables_in = enables_ff;
      slots_in = slots_ff;
      preamp_gain_in = preamp_gain_ff;
      drive_in = drive_ff;
      clip_level_in = clip_level_ff;
      trem_step_in = trem_step_ff;
      trem_depth_in = trem_depth_ff;
      hold_length_in = hold_length_ff;
      trem_phase_in = trem_phase_ff;
      hold_count_in = hold_count_ff;
      held_in = held_ff;
      x_in = x_ff;
      rsp_in = rsp_ff;
      neg_in = neg_ff;
      od_prod_in = od_prod_ff;
      frac_in = frac_ff;
      od_dp_in = od_dp_ff;
      od_base_in = od_base_ff;
      pre_prod_in = pre_prod_ff;
      tp_in = tp_ff;
      qh_in = qh_ff;
      n2_in = n2_ff;
      q2_in = q2_ff;
      g_in = g_ff;
      tr_prod_in = tr_prod_ff;
      fill_idx_in = fill_idx_ff;
      fill_sine_in = fill_sine_ff;
      if (csr_we) begin
         case (csr_index)
            gec_pkg::CFG_ENABLES: enables_in = csr_wdata[5:0];
            gec_pkg::CFG_SLOTS:   slots_in = csr_wdata[11:0];
            gec_pkg::CFG_PREAMP:  preamp_gain_in = csr_wdata[15:0];
            gec_pkg::CFG_DRIVE:   drive_in = csr_wdata[15:0];
            gec_pkg::CFG_CLIP:    clip_level_in = csr_wdata[22:0];
            gec_pkg::CFG_STEP:    trem_step_in = csr_wdata;
            gec_pkg::CFG_DEPTH:   trem_depth_in = csr_wdata[7:0];
            gec_pkg::CFG_HOLD:    hold_length_in = csr_wdata[7:0];
            default: ;
         endcase
      end
      case (op)
         gec_pkg::OP_FILL_STORE: begin
            if (fill_sine_ff) begin
               if (fill_idx_ff == AW'(FUNC_TABLE_DEPTH - 1)) begin
                  fill_sine_in = 1'b0;
                  fill_idx_in = '0;
               end else begin
                  fill_idx_in = fill_idx_ff + AW'(1);
               end
            end else begin
               fill_idx_in = fill_idx_ff + AW'(1);
            end
         end
         gec_pkg::OP_LOAD: x_in = req_sample_in;
         gec_pkg::OP_PRE_MUL:
            pre_prod_in = P2W'(x_ff) * $signed(P2W'({1'b0, preamp_gain_ff}));
         gec_pkg::OP_PRE_FIN:
            x_in = sat_f(WW'((pre_prod_ff + P2W'(2048)) >>> 12));
         gec_pkg::OP_OD_MUL: begin
            od_prod_in = PW'(ax) * PW'(drive_ff);
            neg_in = x_ff[SB-1];
         end
         gec_pkg::OP_OD_RD: frac_in = od_frac;
         gec_pkg::OP_OD_INT: begin
            od_dp_in = 50'(od_diff) * $signed(50'({1'b0, frac_ff}));
            od_base_in = atan_a_ff;
         end
         gec_pkg::OP_OD_FIN: x_in = sat_f(neg_ff ? -WW'(od_r) : WW'(od_r));
         gec_pkg::OP_TR_MUL: tp_in = 39'(dcl) * 39'(u33[31:0]);
         gec_pkg::OP_TR_Q1: qh_in = 14'((37'(h) * 37'(gec_pkg::DIV25_MUL)) >> 23);
         gec_pkg::OP_TR_Q2: begin
            if (rh >= 19'd25) begin
               qh_in = qh_ff + 14'd1;
               n2_in = {5'(rh - 19'd25), tp_ff[20:3]};
            end else begin
               n2_in = {rh[4:0], tp_ff[20:3]};
            end
         end
         gec_pkg::OP_TR_Q3: q2_in = 18'((46'(n2_ff) * 46'(gec_pkg::DIV25_MUL)) >> 23);
         gec_pkg::OP_TR_G: g_in = tr_base;
         gec_pkg::OP_TR_XM: tr_prod_in = TPW'(x_ff) * TPW'(g_ff);
         gec_pkg::OP_TR_FIN: begin
            x_in = sat_f(WW'((tr_prod_ff + TPW'(1 <<< 29)) >>> 30));
            trem_phase_in = trem_phase_ff + trem_step_ff;
         end
         gec_pkg::OP_CLIP: begin
            if (xw > cw) x_in = SB'(cw);
            else if (xw < -cw) x_in = SB'(-cw);
         end
         gec_pkg::OP_HOLD: begin
            if (hold_count_ff == 8'd0) begin
               held_in = x_ff;
            end else begin
               x_in = held_ff;
            end
            hold_count_in = (hc1 != 8'd0) ? hc1 - 8'd1 : 8'd0;
         end
         gec_pkg::OP_OUT: rsp_in = x_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enables_ff <= 6'd0;
         slots_ff <= 12'd0;
         preamp_gain_ff <= 16'd4096;
         drive_ff <= 16'd8192;
         clip_level_ff <= 23'd8388607;
         trem_step_ff <= 32'd0;
         trem_depth_ff <= 8'd0;
         hold_length_ff <= 8'd1;
         trem_phase_ff <= 32'd0;
         hold_count_ff <= 8'd0;
         held_ff <= '0;
         fill_idx_ff <= '0;
         fill_sine_ff <= 1'b1;
      end else begin
         enables_ff <= enables_in;
         slots_ff <= slots_in;
         preamp_gain_ff <= preamp_gain_in;
         drive_ff <= drive_in;
         clip_level_ff <= clip_level_in;
         trem_step_ff <= trem_step_in;
         trem_depth_ff <= trem_depth_in;
         hold_length_ff <= hold_length_in;
         trem_phase_ff <= trem_phase_in;
         hold_count_ff <= hold_count_in;
         held_ff <= held_in;
         fill_idx_ff <= fill_idx_in;
         fill_sine_ff <= fill_sine_in;
      end
      fill_neg_ff <= fill_neg_in;
      x_ff <= x_in;
      rsp_ff <= rsp_in;
      neg_ff <= neg_in;
      od_prod_ff <= od_prod_in;
      frac_ff <= frac_in;
      od_dp_ff <= od_dp_in;
      od_base_ff <= od_base_in;
      pre_prod_ff <= pre_prod_in;
      tp_ff <= tp_in;
      qh_ff <= qh_in;
      n2_ff <= n2_in;
      q2_ff <= q2_in;
      g_ff <= g_in;
      tr_prod_ff <= tr_prod_in;
   end

   always_ff @(posedge clock) begin
      if (op == gec_pkg::OP_FILL_STORE && fill_sine_ff) begin
         sin_mem[fill_idx_ff[L-1:0]] <= sin_wr;
      end
      if (op == gec_pkg::OP_FILL_STORE && !fill_sine_ff) begin
         atan_mem[fill_idx_ff] <= atan_wr;
      end
      sin_rd_ff <= sin_mem[trem_phase_ff[31 -: L]];
      atan_a_ff <= atan_mem[od_a0];
      atan_b_ff <= atan_mem[od_a1];
   end

   assign status.bypass = enables_ff[0];
   assign status.preamp_en = enables_ff[1];
   assign status.eff_en = enables_ff[5:2];
   assign status.slots = slots_ff;
   assign status.cordic_busy = cor_busy;
   assign status.fill_end = !fill_sine_ff && (fill_idx_ff == AW'(FUNC_TABLE_DEPTH));
   assign rsp_sample_out = rsp_ff;

endmodule

/* hdl/gec_ctrl.sv */
`include "guitar_effect_chain_core_defines.svh"

module gec_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  gec_pkg::status_type status,
   output gec_pkg::op_type     op,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready
);

   gec_pkg::state_type state_ff, state_in;
   logic [3:0] pending_ff, pending_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic found;
   logic [1:0] best_e;
   logic [4:0] best_key, key;
   logic [2:0] sl;
   logic [3:0] fresh;

   always_comb begin
      found = 1'b0;
      best_e = gec_pkg::EFF_OD;
      best_key = 5'd0;
      fresh = 4'd0;
      for (int e = 0; e < 4; e++) begin
         sl = status.slots[3*e +: 3];
         key = {sl, 2'(e)};
         fresh[e] = status.eff_en[e] && (sl >= 3'd1) && (sl <= 3'd5);
         if (pending_ff[e] && (!found || key < best_key)) begin
            found = 1'b1;
            best_key = key;
            best_e = 2'(e);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      pending_in = pending_ff;
      rsp_valid_in = rsp_valid_ff;
      op = gec_pkg::OP_NONE;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         gec_pkg::ST_FILL_START: begin
            op = gec_pkg::OP_FILL_START;
            state_in = gec_pkg::ST_FILL_RUN;
         end
         gec_pkg::ST_FILL_RUN: begin
            if (!status.cordic_busy) state_in = gec_pkg::ST_FILL_STORE;
         end
         gec_pkg::ST_FILL_STORE: begin
            op = gec_pkg::OP_FILL_STORE;
            state_in = status.fill_end ? gec_pkg::ST_IDLE : gec_pkg::ST_FILL_START;
         end
         gec_pkg::ST_IDLE: begin
            if (req_valid) begin
               op = gec_pkg::OP_LOAD;
               state_in = gec_pkg::ST_START;
            end
         end
         gec_pkg::ST_START: begin
            if (status.bypass) begin
               state_in = gec_pkg::ST_FINISH;
            end else begin
               pending_in = fresh;
               state_in = status.preamp_en ? gec_pkg::ST_PRE_MUL : gec_pkg::ST_SELECT;
            end
         end
         gec_pkg::ST_PRE_MUL: begin
            op = gec_pkg::OP_PRE_MUL;
            state_in = gec_pkg::ST_PRE_FIN;
         end
         gec_pkg::ST_PRE_FIN: begin
            op = gec_pkg::OP_PRE_FIN;
            state_in = gec_pkg::ST_SELECT;
         end
         gec_pkg::ST_SELECT: begin
            if (found) begin
               pending_in[best_e] = 1'b0;
               case (best_e)
                  gec_pkg::EFF_OD:   state_in = gec_pkg::ST_OD_MUL;
                  gec_pkg::EFF_TREM: state_in = gec_pkg::ST_TR_MUL;
                  gec_pkg::EFF_CLIP: state_in = gec_pkg::ST_CLIP;
                  gec_pkg::EFF_HOLD: state_in = gec_pkg::ST_HOLD;
                  default:           state_in = gec_pkg::ST_FINISH;
               endcase
            end else begin
               state_in = gec_pkg::ST_FINISH;
            end
         end
         gec_pkg::ST_OD_MUL: begin
            op = gec_pkg::OP_OD_MUL;
            state_in = gec_pkg::ST_OD_RD;
         end
         gec_pkg::ST_OD_RD: begin
            op = gec_pkg::OP_OD_RD;
            state_in = gec_pkg::ST_OD_INT;
         end
         gec_pkg::ST_OD_INT: begin
            op = gec_pkg::OP_OD_INT;
            state_in = gec_pkg::ST_OD_FIN;
         end
         gec_pkg::ST_OD_FIN: begin
            op = gec_pkg::OP_OD_FIN;
            state_in = gec_pkg::ST_SELECT;
         end
         gec_pkg::ST_TR_MUL: begin
            op = gec_pkg::OP_TR_MUL;
            state_in = gec_pkg::ST_TR_Q1;
         end
         gec_pkg::ST_TR_Q1: begin
            op = gec_pkg::OP_TR_Q1;
            state_in = gec_pkg::ST_TR_Q2;
         end
         gec_pkg::ST_TR_Q2: begin
            op = gec_pkg::OP_TR_Q2;
            state_in = gec_pkg::ST_TR_Q3;
         end
         gec_pkg::ST_TR_Q3: begin
            op = gec_pkg::OP_TR_Q3;
            state_in = gec_pkg::ST_TR_G;
         end
         gec_pkg::ST_TR_G: begin
            op = gec_pkg::OP_TR_G;
            state_in = gec_pkg::ST_TR_XM;
         end
         gec_pkg::ST_TR_XM: begin
            op = gec_pkg::OP_TR_XM;
            state_in = gec_pkg::ST_TR_FIN;
         end
         gec_pkg::ST_TR_FIN: begin
            op = gec_pkg::OP_TR_FIN;
            state_in = gec_pkg::ST_SELECT;
         end
         gec_pkg::ST_CLIP: begin
            op = gec_pkg::OP_CLIP;
            state_in = gec_pkg::ST_SELECT;
         end
         gec_pkg::ST_HOLD: begin
            op = gec_pkg::OP_HOLD;
            state_in = gec_pkg::ST_SELECT;
         end
         gec_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op = gec_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in = gec_pkg::ST_IDLE;
            end
         end
         default: state_in = gec_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gec_pkg::ST_FILL_START;
         pending_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pending_ff <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == gec_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `GEC_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
   `GEC_ASSERT_NOW(a_idle_clear, clock, reset, state_ff == gec_pkg::ST_IDLE, pending_ff == 4'd0)
   `GEC_ASSERT_NEXT(a_finish_wait, clock, reset,
      state_ff == gec_pkg::ST_FINISH && rsp_valid_ff && !rsp_ready,
      state_ff == gec_pkg::ST_FINISH)

endmodule

/* hdl/guitar_effect_chain_core.sv */
// Each word passes START, the preamp steps if enabled, then each enabled effect with a slot
// of 1 to 5 in slot order, then FINISH, which waits for the output; bypass skips to FINISH.
// Throughput: one word at a time, the next accepted once the result sits in the output register.
// After reset the sine and arctangent tables are built by a shared iterative CORDIC unit,
// one entry at a time, with req_ready low until both are complete.
// Reset is synchronous; configuration returns to defaults, tremolo phase and hold state to zero.
module guitar_effect_chain_core #(
   parameter int SAMPLE_BITS = 24,
   parameter int FUNC_TABLE_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [31:0]                   csr_wdata
);

   gec_pkg::op_type op;
   gec_pkg::status_type status;

   gec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .op        (op),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   gec_datapath #(
      .SAMPLE_BITS      (SAMPLE_BITS),
      .FUNC_TABLE_DEPTH (FUNC_TABLE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .status         (status),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int SB = 24;
   localparam int TAB_N = 1024;
   localparam logic [5:0] EN_BYPASS = 6'h01;
   localparam logic [5:0] EN_PREAMP = 6'h02;
   localparam logic [5:0] EN_OD     = 6'h04;
   localparam logic [5:0] EN_TREM   = 6'h08;
   localparam logic [5:0] EN_CLIP   = 6'h10;
   localparam logic [5:0] EN_HOLD   = 6'h20;
   localparam longint ONE = 64'sd1073741824;
   localparam longint SMAX = 64'sd8388607;
   localparam longint SMIN = -64'sd8388608;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SB-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SB-1:0] rsp_sample_out;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = gec_pkg::CFG_ENABLES;
   logic [31:0] csr_wdata = '0;

   guitar_effect_chain_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_out(rsp_sample_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow of the block
   logic [5:0]  m_enables;
   logic [11:0] m_slots;
   logic [15:0] m_gain, m_drive;
   logic [22:0] m_clip;
   logic [31:0] m_step, m_phase;
   logic [7:0]  m_depth, m_hold_len, m_hold_cnt;
   longint      m_held;
   longint      sine_q30[TAB_N];
   longint      atan_q30[TAB_N+1];
   logic signed [SB-1:0] expected_samples[$];
   int errors = 0;
   int burst_left = 0;

   function automatic longint angle_q30(input int i);
      longint t[30] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
         41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
         10, 5, 3, 1};
      return t[i];
   endfunction

   function automatic void build_tables();
      longint x, y, z, nx;
      bit neg;
      for (int k = 0; k < TAB_N; k++) begin
         z = longint'(k) <<< 22;
         if (z >= 64'sh80000000) z = z - (64'sd1 <<< 32);
         neg = 0;
         if (z > ONE) begin z -= 2 * ONE; neg = 1; end
         else if (z < -ONE) begin z += 2 * ONE; neg = 1; end
         x = 652032875; y = 0;
         for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i); y += x >>> i; z -= angle_q30(i);
            end else begin
               nx = x + (y >>> i); y -= x >>> i; z += angle_q30(i);
            end
            x = nx;
         end
         if (y > ONE) y = ONE;
         if (y < -ONE) y = -ONE;
         sine_q30[k] = neg ? -y : y;
      end
      for (int k = 0; k <= TAB_N; k++) begin
         x = ONE; y = longint'(k) <<< 24; z = 0;
         for (int i = 0; i < 30; i++) begin
            if (y >= 0) begin
               nx = x + (y >>> i); y -= x >>> i; z += angle_q30(i);
            end else begin
               nx = x - (y >>> i); y += x >>> i; z -= angle_q30(i);
            end
            x = nx;
         end
         if (z < 0) z = 0;
         if (z > ONE) z = ONE;
         atan_q30[k] = z;
      end
   endfunction

   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(input longint v);
      return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
   endfunction

   function automatic longint overdrive(input longint x);
      longint ax, pos, idx, f, v, r;
      bit neg;
      neg = x < 0;
      ax = neg ? -x : x;
      pos = ax * longint'(m_drive) * TAB_N;
      idx = pos >>> 39;
      if (idx >= TAB_N) v = atan_q30[TAB_N];
      else begin
         f = (pos >>> 23) & 64'hFFFF;
         v = atan_q30[idx] + (((atan_q30[idx+1] - atan_q30[idx]) * f) >>> 16);
      end
      r = round_shift(v * (64'sd1 <<< 23), 30);
      return clamp(neg ? -r : r);
   endfunction

   function automatic longint tremolo(input longint x);
      longint s, d, g;
      s = sine_q30[m_phase >> 22];
      d = m_depth > 200 ? 200 : longint'(m_depth);
      g = (200 * ONE + d * (s - ONE)) / 200;
      m_phase = m_phase + m_step;
      return clamp(round_shift(x * g, 30));
   endfunction

   function automatic logic signed [SB-1:0] chain_output(input logic signed [SB-1:0] s);
      longint x;
      x = s;
      if (!(m_enables & EN_BYPASS)) begin
         if (m_enables & EN_PREAMP) x = clamp(round_shift(x * longint'(m_gain), 12));
         for (int slot = 1; slot < 6; slot++) begin
            if ((m_enables & EN_OD) && m_slots[2:0] == slot) x = overdrive(x);
            if ((m_enables & EN_TREM) && m_slots[5:3] == slot) x = tremolo(x);
            if ((m_enables & EN_CLIP) && m_slots[8:6] == slot) begin
               if (x > longint'(m_clip)) x = m_clip;
               else if (x < -longint'(m_clip)) x = -longint'(m_clip);
            end
            if ((m_enables & EN_HOLD) && m_slots[11:9] == slot) begin
               if (m_hold_cnt == 0) begin
                  m_held = x;
                  m_hold_cnt = m_hold_len;
               end
               if (m_hold_cnt > 0) m_hold_cnt--;
               x = m_held;
            end
         end
      end
      return x[SB-1:0];
   endfunction

   // registers change only with nothing in flight
   task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
      if (req_valid) req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         gec_pkg::CFG_ENABLES: m_enables = val[5:0];
         gec_pkg::CFG_SLOTS:   m_slots = val[11:0];
         gec_pkg::CFG_PREAMP:  m_gain = val[15:0];
         gec_pkg::CFG_DRIVE:   m_drive = val[15:0];
         gec_pkg::CFG_CLIP:    m_clip = val[22:0];
         gec_pkg::CFG_STEP:    m_step = val;
         gec_pkg::CFG_DEPTH:   m_depth = val[7:0];
         gec_pkg::CFG_HOLD:    m_hold_len = val[7:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_word(input logic signed [SB-1:0] s);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (!req_ready);
      expected_samples.push_back(chain_output(s));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic signed [SB-1:0] any_sample();
      logic signed [SB-1:0] extremes[6] = '{24'sh7FFFFF, 24'sh800000, 24'sh000000,
                                            24'sh000001, 24'shFFFFFF, 24'sh800001};
      case ($urandom_range(0, 3))
         0: return extremes[$urandom_range(0, 5)];
         1: return $urandom_range(0, 2000) - 1000;
         2: return $urandom_range(0, 65535) - 32768;
         default: return $urandom();
      endcase
   endfunction

   task automatic test_bypass();
      set_reg(gec_pkg::CFG_ENABLES, 32'hFFFFFFFF);
      set_reg(gec_pkg::CFG_SLOTS, 12'o1234);
      send_word(24'sh7FFFFF);
      send_word(24'sh800000);
      send_word(24'sh000000);
      send_word(24'sh555555);
      send_word(24'shAAAAAA);
      drain();
   endtask

   task automatic test_preamp();
      set_reg(gec_pkg::CFG_ENABLES, EN_PREAMP);
      set_reg(gec_pkg::CFG_PREAMP, 32'hFFFF);
      send_word(24'sh7FFFFF);
      send_word(24'sh800000);
      send_word(24'sh000001);
      set_reg(gec_pkg::CFG_PREAMP, 0);
      send_word(24'sh7FFFFF);
      set_reg(gec_pkg::CFG_PREAMP, 2048);
      send_word(24'shFFFFFF);
      send_word(24'sh000001);
      drain();
   endtask

   task automatic test_overdrive();
      set_reg(gec_pkg::CFG_ENABLES, EN_OD);
      set_reg(gec_pkg::CFG_SLOTS, 12'o0001);
      set_reg(gec_pkg::CFG_DRIVE, 32'hFFFF);
      send_word(24'sh7FFFFF);
      send_word(24'sh800000);
      send_word(24'sh012345);
      set_reg(gec_pkg::CFG_DRIVE, 0);
      send_word(24'sh7FFFFF);
      set_reg(gec_pkg::CFG_DRIVE, 8192);
      send_word(24'sh400000);
      send_word(24'shC00000);
      drain();
   endtask

   task automatic test_tremolo();
      set_reg(gec_pkg::CFG_ENABLES, EN_TREM);
      set_reg(gec_pkg::CFG_SLOTS, 12'o0050);
      set_reg(gec_pkg::CFG_DEPTH, 255);
      set_reg(gec_pkg::CFG_STEP, 32'hFFFFFFFF);
      repeat (3) send_word(24'sh7FFFFF);
      set_reg(gec_pkg::CFG_STEP, 32'h40000000);
      set_reg(gec_pkg::CFG_DEPTH, 200);
      repeat (4) send_word(24'sh800000);
      drain();
   endtask

   task automatic test_clip_hold();
      set_reg(gec_pkg::CFG_ENABLES, EN_CLIP | EN_HOLD);
      set_reg(gec_pkg::CFG_SLOTS, 12'o3200);
      set_reg(gec_pkg::CFG_CLIP, 0);
      send_word(24'sh7FFFFF);
      set_reg(gec_pkg::CFG_CLIP, 32'h7FFFFF);
      send_word(24'sh800000);
      set_reg(gec_pkg::CFG_HOLD, 3);
      repeat (4) send_word(any_sample());
      set_reg(gec_pkg::CFG_HOLD, 0);
      send_word(24'sh123456);
      set_reg(gec_pkg::CFG_SLOTS, 12'o7600);
      send_word(24'sh7FFFFF);
      drain();
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 14; ph++) begin
         set_reg(gec_pkg::CFG_ENABLES,
                 $urandom_range(0, 7) == 0 ? 6'h01 : ($urandom() & 6'h3E));
         set_reg(gec_pkg::CFG_SLOTS, $urandom_range(0, 4) == 0 ? $urandom() : {
            3'($urandom_range(1, 5)), 3'($urandom_range(1, 5)),
            3'($urandom_range(1, 5)), 3'($urandom_range(1, 5))});
         set_reg(gec_pkg::CFG_PREAMP, ph % 5 == 0 ? 16'hFFFF : $urandom_range(0, 65535));
         set_reg(gec_pkg::CFG_DRIVE, ph % 4 == 1 ? 16'hFFFF : $urandom_range(0, 65535));
         set_reg(gec_pkg::CFG_CLIP, ph % 6 == 2 ? 0 : $urandom());
         set_reg(gec_pkg::CFG_STEP, ph % 3 == 0 ? 32'hFFFFFFFF : $urandom());
         set_reg(gec_pkg::CFG_DEPTH, $urandom_range(0, 255));
         set_reg(gec_pkg::CFG_HOLD, ph % 7 == 3 ? 255 : $urandom_range(0, 8));
         repeat (108) send_word(any_sample());
         drain();
      end
   endtask

   // receiver with changing stall pattern
   int stall_mode = 0;
   int stall_cnt = 0;
   always @(posedge clock) begin
      if (stall_cnt == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_cnt <= $urandom_range(20, 120);
      end else begin
         stall_cnt <= stall_cnt - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= (stall_cnt % 5) == 0;
         default: rsp_ready <= $urandom_range(0, 7) != 0;
      endcase
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $error("sample_out: no word expected, actual %0d", rsp_sample_out);
            errors++;
         end else begin
            if (rsp_sample_out !== expected_samples[0]) begin
               $error("sample_out mismatch: expected %0d, actual %0d",
                      expected_samples[0], rsp_sample_out);
               errors++;
            end
            void'(expected_samples.pop_front());
         end
      end
   end

   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      m_enables = 0; m_slots = 0; m_gain = 4096; m_drive = 8192;
      m_clip = 23'h7FFFFF; m_step = 0; m_depth = 0; m_hold_len = 1;
      m_phase = 0; m_held = 0; m_hold_cnt = 0;
      build_tables();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bypass();
      test_preamp();
      test_overdrive();
      test_tremolo();
      test_clip_hold();
      test_random();
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hdl
hdl/gec_pkg.sv
hdl/gec_cordic.sv
hdl/gec_datapath.sv
hdl/gec_ctrl.sv
hdl/guitar_effect_chain_core.sv
tb/sv/tb_top.sv
